FILE: hw/rtl/ack_retransmit_controller_assert.svh
// Assertion helpers shared by the controller RTL.
`ifndef ACK_RETRANSMIT_CONTROLLER_ASSERT_SVH
`define ACK_RETRANSMIT_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define ARC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ARC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/arc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_pkg
// Types, codes and defaults shared by the ack/retransmit controller.
// ----------------------------------------------------------------------------
package arc_pkg;

    localparam int MAX_TEXT_BYTES_DEF = 1024;
    localparam int CHUNK_BYTES_DEF    = 128;

    localparam int MAX_CHUNKS = 8;

    // Input kinds
    localparam logic [2:0] KIND_TICK   = 3'd0;
    localparam logic [2:0] KIND_NOTE   = 3'd1;
    localparam logic [2:0] KIND_SNAP   = 3'd2;
    localparam logic [2:0] KIND_ACK    = 3'd3;
    localparam logic [2:0] KIND_CANCEL = 3'd4;

    // Start status codes
    localparam logic [2:0] STATUS_NONE    = 3'd0;
    localparam logic [2:0] STATUS_STARTED = 3'd1;
    localparam logic [2:0] STATUS_BUSY    = 3'd2;
    localparam logic [2:0] STATUS_PLAYING = 3'd3;
    localparam logic [2:0] STATUS_INVALID = 3'd4;
    localparam logic [2:0] STATUS_RADIO   = 3'd5;

    // Outcome codes
    localparam logic [1:0] OUTCOME_NONE    = 2'd0;
    localparam logic [1:0] OUTCOME_SENT    = 2'd1;
    localparam logic [1:0] OUTCOME_TIMEOUT = 2'd2;

    // Snapshot control types
    localparam logic [1:0] SNAP_COMMIT = 2'd1;

    // Mode codes as reported on the result
    localparam logic [1:0] MODE_CODE_IDLE      = 2'd0;
    localparam logic [1:0] MODE_CODE_SENDING   = 2'd1;
    localparam logic [1:0] MODE_CODE_READY     = 2'd2;
    localparam logic [1:0] MODE_CODE_RESTORING = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_RETRY_INTERVAL  = 2'd0;
    localparam logic [1:0] CFG_CHUNK_INTERVAL  = 2'd1;
    localparam logic [1:0] CFG_SEND_TIMEOUT    = 2'd2;
    localparam logic [1:0] CFG_RESTORE_TIMEOUT = 2'd3;

    localparam logic [9:0]  RETRY_INTERVAL_RST  = 10'd350;
    localparam logic [9:0]  CHUNK_INTERVAL_RST  = 10'd100;
    localparam logic [15:0] SEND_TIMEOUT_RST    = 16'd30000;
    localparam logic [15:0] RESTORE_TIMEOUT_RST = 16'd8000;

    typedef enum logic [3:0] {
        MODE_IDLE      = 4'b0001,
        MODE_SENDING   = 4'b0010,
        MODE_READY     = 4'b0100,
        MODE_RESTORING = 4'b1000
    } t_mode;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] sequence_req;
        logic [10:0] message_length;
        logic        note_valid;
        logic        chunked_format;
        logic [1:0]  snapshot_control;
        logic        keep_radio;
        logic        radio_playing;
        logic        radio_ok;
        logic        link_connected;
    } t_item;

    typedef struct packed {
        logic [2:0] start_status;
        logic       send_now;
        logic [2:0] chunk_index;
        logic       send_snapshot;
        logic [1:0] outcome;
        logic       busy_res;
        logic [1:0] mode_now;
    } t_res;

    typedef struct packed {
        logic [9:0]  retry_interval;
        logic [9:0]  chunk_interval;
        logic [15:0] send_timeout;
        logic [15:0] restore_timeout;
    } t_cfg;

    function automatic logic [1:0] mode_code(input t_mode m);
        logic [1:0] c;
        unique case (m)
            MODE_IDLE:      c = MODE_CODE_IDLE;
            MODE_SENDING:   c = MODE_CODE_SENDING;
            MODE_READY:     c = MODE_CODE_READY;
            MODE_RESTORING: c = MODE_CODE_RESTORING;
            default:        c = MODE_CODE_IDLE;
        endcase
        return c;
    endfunction

endpackage

FILE: hw/rtl/arc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_core
// Transfer state and the one-pass step logic: start, tick, ack and cancel.
// ----------------------------------------------------------------------------
`include "ack_retransmit_controller_assert.svh"

module arc_core #(
    parameter int MAX_TEXT_BYTES = arc_pkg::MAX_TEXT_BYTES_DEF,
    parameter int CHUNK_BYTES    = arc_pkg::CHUNK_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  arc_pkg::t_item i_item,
    input  arc_pkg::t_cfg  i_cfg,
    output arc_pkg::t_res  o_res
);
    import arc_pkg::*;

    t_mode       r_mode, n_mode;
    logic        r_is_snapshot, n_is_snapshot;
    logic [31:0] r_active_seq, n_active_seq;
    logic [31:0] r_acked_seq, n_acked_seq;
    logic        r_stay_ready, n_stay_ready;
    logic        r_use_chunk_iv, n_use_chunk_iv;
    logic [2:0]  r_next_chunk, n_next_chunk;
    logic [3:0]  r_chunk_total, n_chunk_total;
    logic [15:0] r_since_start, n_since_start;
    logic [9:0]  r_since_send, n_since_send;
    logic [15:0] r_since_restore, n_since_restore;
    logic        r_link_was_up, n_link_was_up;

    logic        is_snap_start;
    logic        start_bad;
    logic        do_restore;
    logic        do_emit;
    logic [9:0]  interval;
    logic [15:0] len_ext;
    logic [3:0]  chunk_cnt;
    t_res        res;

    // Chunk count: one plus the number of chunk boundaries the text crosses, capped at MAX_CHUNKS.
    always_comb begin
        len_ext   = {5'd0, i_item.message_length};
        chunk_cnt = 4'd1;
        for (int k = 1; k < MAX_CHUNKS; k++) begin
            if (len_ext > 16'(k * CHUNK_BYTES)) begin
                chunk_cnt = chunk_cnt + 4'd1;
            end
        end
    end

    always_comb begin
        n_mode          = r_mode;
        n_is_snapshot   = r_is_snapshot;
        n_active_seq    = r_active_seq;
        n_acked_seq     = r_acked_seq;
        n_stay_ready    = r_stay_ready;
        n_use_chunk_iv  = r_use_chunk_iv;
        n_next_chunk    = r_next_chunk;
        n_chunk_total   = r_chunk_total;
        n_since_start   = r_since_start;
        n_since_send    = r_since_send;
        n_since_restore = r_since_restore;
        n_link_was_up   = r_link_was_up;
        res             = '0;
        res.start_status = STATUS_NONE;
        res.outcome      = OUTCOME_NONE;
        do_restore      = 1'b0;
        do_emit         = 1'b0;
        is_snap_start   = (i_item.kind == KIND_SNAP);
        interval        = r_use_chunk_iv ? i_cfg.chunk_interval : i_cfg.retry_interval;
        if (is_snap_start) begin
            start_bad = (i_item.sequence_req == 32'd0) ||
                        (i_item.snapshot_control > SNAP_COMMIT);
        end else begin
            start_bad = !i_item.note_valid || (i_item.message_length == 11'd0) ||
                        (len_ext > 16'(MAX_TEXT_BYTES));
        end

        unique case (i_item.kind) inside
            KIND_TICK: begin
                if (r_mode == MODE_SENDING) begin
                    if (r_since_start != 16'hFFFF) n_since_start = r_since_start + 16'd1;
                    if (r_since_send != 10'h3FF) n_since_send = r_since_send + 10'd1;
                    n_acked_seq = '0;
                    if (r_acked_seq == r_active_seq) begin
                        res.outcome = OUTCOME_SENT;
                        if (r_stay_ready) n_mode = MODE_READY;
                        else do_restore = 1'b1;
                    end else if (n_since_start >= i_cfg.send_timeout) begin
                        res.outcome = OUTCOME_TIMEOUT;
                        do_restore  = 1'b1;
                    end else if (n_since_send >= interval) begin
                        do_emit = 1'b1;
                    end
                end else if (r_mode == MODE_RESTORING) begin
                    if (r_since_restore != 16'hFFFF) begin
                        n_since_restore = r_since_restore + 16'd1;
                    end
                    if (i_item.link_connected || n_since_restore >= i_cfg.restore_timeout) begin
                        n_mode = MODE_IDLE;
                    end
                end
            end
            KIND_NOTE, KIND_SNAP: begin
                if (r_mode == MODE_SENDING || r_mode == MODE_RESTORING) begin
                    res.start_status = STATUS_BUSY;
                end else if (i_item.radio_playing) begin
                    res.start_status = STATUS_PLAYING;
                end else if (start_bad) begin
                    res.start_status = STATUS_INVALID;
                end else begin
                    n_is_snapshot = is_snap_start;
                    n_stay_ready  = i_item.keep_radio;
                    n_next_chunk  = '0;
                    if (is_snap_start) begin
                        n_active_seq   = i_item.sequence_req;
                        n_use_chunk_iv = 1'b0;
                        n_chunk_total  = 4'd1;
                    end else begin
                        n_active_seq   = (i_item.sequence_req == 32'd0) ? 32'd1
                                                                        : i_item.sequence_req;
                        n_use_chunk_iv = i_item.chunked_format;
                        n_chunk_total  = chunk_cnt;
                    end
                    n_acked_seq = '0;
                    // Link state is sampled only when the radio session is opened here.
                    if (r_mode != MODE_READY) n_link_was_up = i_item.link_connected;
                    if (!i_item.radio_ok) begin
                        res.start_status = STATUS_RADIO;
                        do_restore       = 1'b1;
                    end else begin
                        res.start_status = STATUS_STARTED;
                        n_mode           = MODE_SENDING;
                        n_since_start    = '0;
                        do_emit          = 1'b1;
                    end
                end
            end
            KIND_ACK: begin
                if ((r_mode == MODE_SENDING || r_mode == MODE_READY) &&
                    i_item.sequence_req == r_active_seq) begin
                    n_acked_seq = i_item.sequence_req;
                end
            end
            KIND_CANCEL: begin
                if (r_mode == MODE_SENDING || r_mode == MODE_READY) do_restore = 1'b1;
            end
            default: begin
            end
        endcase

        if (do_restore) begin
            if (n_link_was_up) begin
                n_since_restore = '0;
                n_mode          = MODE_RESTORING;
            end else begin
                n_mode = MODE_IDLE;
            end
        end

        if (do_emit) begin
            res.send_now      = 1'b1;
            res.send_snapshot = n_is_snapshot;
            res.chunk_index   = n_is_snapshot ? 3'd0 : n_next_chunk;
            n_since_send      = '0;
            // Rotate modulo the chunk count; a zero count behaves as one.
            if (!n_is_snapshot) begin
                if (({1'b0, n_next_chunk} + 4'd1) >= n_chunk_total) n_next_chunk = '0;
                else n_next_chunk = n_next_chunk + 3'd1;
            end
        end

        res.mode_now = mode_code(n_mode);
        res.busy_res = (n_mode == MODE_SENDING) || (n_mode == MODE_RESTORING);
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= MODE_IDLE;
            r_is_snapshot   <= 1'b0;
            r_active_seq    <= '0;
            r_acked_seq     <= '0;
            r_stay_ready    <= 1'b0;
            r_use_chunk_iv  <= 1'b0;
            r_next_chunk    <= '0;
            r_chunk_total   <= '0;
            r_since_start   <= '0;
            r_since_send    <= '0;
            r_since_restore <= '0;
            r_link_was_up   <= 1'b0;
        end else if (i_step) begin
            r_mode          <= n_mode;
            r_is_snapshot   <= n_is_snapshot;
            r_active_seq    <= n_active_seq;
            r_acked_seq     <= n_acked_seq;
            r_stay_ready    <= n_stay_ready;
            r_use_chunk_iv  <= n_use_chunk_iv;
            r_next_chunk    <= n_next_chunk;
            r_chunk_total   <= n_chunk_total;
            r_since_start   <= n_since_start;
            r_since_send    <= n_since_send;
            r_since_restore <= n_since_restore;
            r_link_was_up   <= n_link_was_up;
        end
    end

    `ARC_ASSERT_IMP(a_chunk_in_range, i_clk, i_rst_n,
        r_mode == MODE_SENDING && !r_is_snapshot, {1'b0, r_next_chunk} < r_chunk_total)
    `ARC_ASSERT_IMP(a_chunk_total_max, i_clk, i_rst_n, 1'b1, r_chunk_total <= 4'(MAX_CHUNKS))
    `ARC_ASSERT_NEXT(a_outcome_ends_send, i_clk, i_rst_n,
        i_step && o_res.outcome != OUTCOME_NONE, r_mode != MODE_SENDING)

endmodule

FILE: hw/rtl/ack_retransmit_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ack_retransmit_controller
// Repeat-until-acknowledged transmit controller with stream in/out channels.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel carries one event per transfer: tuser is the kind (tick,
//   start note, start snapshot, ack, cancel), tdata the event fields.
//   Master channel returns exactly one result per event: start status, send
//   request with chunk index, outcome and the mode after the event.
//   Configuration registers (intervals and timeouts) are written through
//   i_cfg_we/i_cfg_idx/i_cfg_data while no event is in flight.
//   An accepted event waits in the input register until the result register
//   is free or draining (two register stages: input and result register).
//   Throughput: one event per cycle while the receiver takes results; the whole
//   step is one pass of compares and counter updates between the two registers.
//   Reset: mode idle, all timers and sequences zero, registers at defaults,
//   both channels empty.
//   Receiver stall: the result register holds; one more event is taken into
//   the input register, after which s tready falls until the result drains.
// ----------------------------------------------------------------------------
`include "ack_retransmit_controller_assert.svh"

module ack_retransmit_controller #(
    parameter int MAX_TEXT_BYTES = arc_pkg::MAX_TEXT_BYTES_DEF,
    parameter int CHUNK_BYTES    = arc_pkg::CHUNK_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tdata: sequence_req[31:0], message_length[42:32], note_valid[43],
    //        chunked_format[44], snapshot_control[46:45], keep_radio[47],
    //        radio_playing[48], radio_ok[49], link_connected[50], zero fill
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [55:0] i_s_axis_tdata,
    // tuser: kind[2:0]
    input  logic [2:0]  i_s_axis_tuser,
    // tdata: start_status[2:0], send_now[3], chunk_index[6:4],
    //        send_snapshot[7], outcome[9:8], busy_res[10], mode_now[12:11],
    //        zero fill
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import arc_pkg::*;

    logic  r_in_valid;
    t_item r_in;
    logic  r_out_valid;
    t_res  r_out;
    t_cfg  r_cfg;
    t_res  step_res;
    logic  advance;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    // Input register: latch a transfer whenever the slot is free or draining.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in.kind             <= i_s_axis_tuser;
            r_in.sequence_req     <= i_s_axis_tdata[31:0];
            r_in.message_length   <= i_s_axis_tdata[42:32];
            r_in.note_valid       <= i_s_axis_tdata[43];
            r_in.chunked_format   <= i_s_axis_tdata[44];
            r_in.snapshot_control <= i_s_axis_tdata[46:45];
            r_in.keep_radio       <= i_s_axis_tdata[47];
            r_in.radio_playing    <= i_s_axis_tdata[48];
            r_in.radio_ok         <= i_s_axis_tdata[49];
            r_in.link_connected   <= i_s_axis_tdata[50];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.retry_interval  <= RETRY_INTERVAL_RST;
            r_cfg.chunk_interval  <= CHUNK_INTERVAL_RST;
            r_cfg.send_timeout    <= SEND_TIMEOUT_RST;
            r_cfg.restore_timeout <= RESTORE_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RETRY_INTERVAL:  r_cfg.retry_interval  <= i_cfg_data[9:0];
                CFG_CHUNK_INTERVAL:  r_cfg.chunk_interval  <= i_cfg_data[9:0];
                CFG_SEND_TIMEOUT:    r_cfg.send_timeout    <= i_cfg_data;
                CFG_RESTORE_TIMEOUT: r_cfg.restore_timeout <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    arc_core #(
        .MAX_TEXT_BYTES (MAX_TEXT_BYTES),
        .CHUNK_BYTES    (CHUNK_BYTES)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_res   (step_res)
    );

    // Result register: hold while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'd0, r_out.mode_now, r_out.busy_res, r_out.outcome,
                              r_out.send_snapshot, r_out.chunk_index, r_out.send_now,
                              r_out.start_status};

    `ARC_ASSERT_IMP(a_stall_has_item, i_clk, i_rst_n, !o_s_axis_tready, r_in_valid)
    `ARC_ASSERT_IMP(a_busy_matches_mode, i_clk, i_rst_n, r_out_valid,
        r_out.busy_res == (r_out.mode_now == MODE_CODE_SENDING ||
                           r_out.mode_now == MODE_CODE_RESTORING))
    `ARC_ASSERT_IMP(a_quiet_no_chunk, i_clk, i_rst_n, r_out_valid && !r_out.send_now,
        r_out.chunk_index == 3'd0 && !r_out.send_snapshot)

endmodule

FILE: tb/sv/tb_ack_retransmit_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ack_retransmit_controller
// Stream-level test of the ack/retransmit controller. Events go in on the
// slave channel and one response per event comes back on the master channel.
// A ledger class mirrors the controller state and predicts each response.
// The run covers refused starts, resends with chunk rotation, acks,
// timeouts and link restore. Register settings change between phases,
// and both channels stall at random.
// ----------------------------------------------------------------------------
module tb_ack_retransmit_controller;
    import arc_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int          HOLD_CYCLES  = 80;
    localparam int          PHASES       = 9;
    localparam int          PHASE_EVENTS = 90;
    localparam logic [2:0]  KIND_UNUSED  = 3'd7;

    // Mirror of the controller: tracks the transfer state and owes one
    // response for every accepted event.
    class retransmit_ledger;
        logic [9:0]  retry_iv;
        logic [9:0]  chunk_iv;
        logic [15:0] send_to;
        logic [15:0] restore_to;
        logic [1:0]  mode;
        bit          is_snap;
        logic [31:0] active_seq;
        logic [31:0] acked_seq;
        bit          stay_ready;
        bit          use_chunk;
        logic [2:0]  next_chunk;
        logic [3:0]  chunk_total;
        logic [15:0] since_start;
        logic [9:0]  since_send;
        logic [15:0] since_restore;
        bit          link_was_up;
        t_res        owed[$];
        int          mismatches;
        int          responses;

        function new();
            retry_iv      = RETRY_INTERVAL_RST;
            chunk_iv      = CHUNK_INTERVAL_RST;
            send_to       = SEND_TIMEOUT_RST;
            restore_to    = RESTORE_TIMEOUT_RST;
            mode          = MODE_CODE_IDLE;
            is_snap       = 1'b0;
            active_seq    = '0;
            acked_seq     = '0;
            stay_ready    = 1'b0;
            use_chunk     = 1'b0;
            next_chunk    = '0;
            chunk_total   = '0;
            since_start   = '0;
            since_send    = '0;
            since_restore = '0;
            link_was_up   = 1'b0;
            mismatches    = 0;
            responses     = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] value);
            case (idx)
                CFG_RETRY_INTERVAL:  retry_iv   = value[9:0];
                CFG_CHUNK_INTERVAL:  chunk_iv   = value[9:0];
                CFG_SEND_TIMEOUT:    send_to    = value;
                CFG_RESTORE_TIMEOUT: restore_to = value;
                default: ;
            endcase
        endfunction

        function void enter_restore();
            if (link_was_up) begin
                since_restore = '0;
                mode          = MODE_CODE_RESTORING;
            end else begin
                mode = MODE_CODE_IDLE;
            end
        endfunction

        // Request a send and advance to the next chunk of a note.
        function void send_packet(inout t_res r);
            int unsigned span;
            r.send_now      = 1'b1;
            r.send_snapshot = is_snap;
            r.chunk_index   = is_snap ? 3'd0 : next_chunk;
            since_send      = '0;
            if (!is_snap) begin
                span       = (chunk_total != 0) ? chunk_total : 1;
                next_chunk = 3'((next_chunk + 1) % span);
            end
        endfunction

        function void log_event(t_item it);
            t_res        r;
            logic [31:0] ack_seen;
            logic [9:0]  gap;
            int unsigned chunks;
            bit          snap;
            r = '0;
            case (it.kind)
                KIND_TICK: begin
                    if (mode == MODE_CODE_SENDING) begin
                        ack_seen = acked_seq;
                        if (since_start != 16'hFFFF) since_start++;
                        if (since_send != 10'h3FF) since_send++;
                        acked_seq = '0;
                        if (ack_seen == active_seq) begin
                            r.outcome = OUTCOME_SENT;
                            if (stay_ready) mode = MODE_CODE_READY;
                            else enter_restore();
                        end else if (since_start >= send_to) begin
                            r.outcome = OUTCOME_TIMEOUT;
                            enter_restore();
                        end else begin
                            gap = use_chunk ? chunk_iv : retry_iv;
                            if (since_send >= gap) send_packet(r);
                        end
                    end else if (mode == MODE_CODE_RESTORING) begin
                        if (since_restore != 16'hFFFF) since_restore++;
                        if (it.link_connected || since_restore >= restore_to)
                            mode = MODE_CODE_IDLE;
                    end
                end
                KIND_NOTE, KIND_SNAP: begin
                    snap = (it.kind == KIND_SNAP);
                    if (mode != MODE_CODE_IDLE && mode != MODE_CODE_READY) begin
                        r.start_status = STATUS_BUSY;
                    end else if (it.radio_playing) begin
                        r.start_status = STATUS_PLAYING;
                    end else if (snap ? (it.sequence_req == 0 ||
                                         it.snapshot_control > SNAP_COMMIT)
                                      : (!it.note_valid || it.message_length == 0 ||
                                         it.message_length > MAX_TEXT_BYTES_DEF)) begin
                        r.start_status = STATUS_INVALID;
                    end else begin
                        is_snap    = snap;
                        stay_ready = it.keep_radio;
                        next_chunk = '0;
                        if (snap) begin
                            active_seq  = it.sequence_req;
                            use_chunk   = 1'b0;
                            chunk_total = 4'd1;
                        end else begin
                            chunks = (it.message_length + CHUNK_BYTES_DEF - 1) / CHUNK_BYTES_DEF;
                            if (chunks > MAX_CHUNKS) chunks = MAX_CHUNKS;
                            if (chunks == 0) chunks = 1;
                            chunk_total = 4'(chunks);
                            active_seq  = (it.sequence_req != 0) ? it.sequence_req : 32'd1;
                            use_chunk   = it.chunked_format;
                        end
                        acked_seq = '0;
                        // a start from radio ready keeps the earlier link state
                        if (mode != MODE_CODE_READY) link_was_up = it.link_connected;
                        if (!it.radio_ok) begin
                            r.start_status = STATUS_RADIO;
                            enter_restore();
                        end else begin
                            r.start_status = STATUS_STARTED;
                            mode           = MODE_CODE_SENDING;
                            since_start    = '0;
                            send_packet(r);
                        end
                    end
                end
                KIND_ACK: begin
                    if ((mode == MODE_CODE_SENDING || mode == MODE_CODE_READY) &&
                        it.sequence_req == active_seq)
                        acked_seq = it.sequence_req;
                end
                KIND_CANCEL: begin
                    if (mode == MODE_CODE_SENDING || mode == MODE_CODE_READY)
                        enter_restore();
                end
                default: ;
            endcase
            r.busy_res = (mode == MODE_CODE_SENDING || mode == MODE_CODE_RESTORING);
            r.mode_now = mode;
            owed.push_back(r);
        endfunction

        task flag_mismatch(string msg);
            mismatches++;
            $display("MISMATCH @%0t: %s", $time, msg);
        endtask

        task cmp(string name, logic [2:0] got, logic [2:0] want);
            if (got !== want)
                flag_mismatch($sformatf("response %0d %s: got %0d, expected %0d",
                                        responses, name, got, want));
        endtask

        task check_response(logic [15:0] d);
            t_res want;
            if (owed.size() == 0) begin
                flag_mismatch($sformatf("response %h with nothing owed", d));
                return;
            end
            want = owed.pop_front();
            cmp("start_status", d[2:0], want.start_status);
            cmp("send_now", 3'(d[3]), 3'(want.send_now));
            cmp("chunk_index", d[6:4], want.chunk_index);
            cmp("send_snapshot", 3'(d[7]), 3'(want.send_snapshot));
            cmp("outcome", 3'(d[9:8]), 3'(want.outcome));
            cmp("busy_res", 3'(d[10]), 3'(want.busy_res));
            cmp("mode_now", 3'(d[12:11]), 3'(want.mode_now));
            cmp("fill", d[15:13], 3'd0);
            responses++;
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [55:0] i_s_axis_tdata;
    logic [2:0]  i_s_axis_tuser;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [15:0] o_m_axis_tdata;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    retransmit_ledger ledger;
    int unsigned      cycle_count = 0;
    int               hold_left   = 0;
    bit               hold_request = 1'b0;
    bit               idle_on      = 1'b0;

    ack_retransmit_controller dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ack_retransmit_controller test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            ledger.check_response(o_m_axis_tdata);
    end

    // Response side: random stall bursts, plus one long hold on request.
    initial begin
        int stall_left;
        stall_left = 0;
        i_m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 16) - 1;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic t_item blank(logic [2:0] k);
        t_item it;
        it      = '0;
        it.kind = k;
        return it;
    endfunction

    // Pick the next event from the predicted mode: mostly well-formed
    // transfers with random content, the rest refused starts and noise.
    function automatic t_item make_item();
        t_item       it;
        int unsigned pick;
        it.kind             = KIND_TICK;
        it.sequence_req     = $urandom;
        it.message_length   = 11'($urandom_range(0, 2047));
        it.note_valid       = 1'($urandom_range(0, 1));
        it.chunked_format   = 1'($urandom_range(0, 1));
        it.snapshot_control = 2'($urandom_range(0, 3));
        it.keep_radio       = 1'($urandom_range(0, 1));
        it.radio_playing    = 1'($urandom_range(0, 1));
        it.radio_ok         = 1'($urandom_range(0, 1));
        it.link_connected   = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        case (ledger.mode)
            MODE_CODE_SENDING: begin
                if (pick < 72) begin
                    it.kind = KIND_TICK;
                end else if (pick < 80) begin
                    it.kind         = KIND_ACK;
                    it.sequence_req = ledger.active_seq;
                end else if (pick < 84) begin
                    it.kind = KIND_ACK;
                end else if (pick < 88) begin
                    it.kind = KIND_CANCEL;
                end else if (pick < 95) begin
                    it.kind = pick[0] ? KIND_NOTE : KIND_SNAP;
                end else begin
                    it.kind = 3'($urandom_range(5, 7));
                end
            end
            MODE_CODE_RESTORING: begin
                if (pick < 80) begin
                    it.kind           = KIND_TICK;
                    it.link_connected = (pick < 20);
                end else if (pick < 90) begin
                    it.kind = pick[0] ? KIND_NOTE : KIND_SNAP;
                end else begin
                    it.kind = 3'($urandom_range(0, 7));
                end
            end
            default: begin
                if (pick < 55) begin
                    it.kind             = pick[0] ? KIND_NOTE : KIND_SNAP;
                    it.note_valid       = 1'b1;
                    it.radio_playing    = 1'b0;
                    it.radio_ok         = (pick >= 5);
                    it.snapshot_control = 2'($urandom_range(0, 1));
                    it.message_length   = (pick < 15) ? 11'($urandom_range(1, 1024))
                                                      : 11'($urandom_range(1, 384));
                    if (it.kind == KIND_SNAP && it.sequence_req == 0) it.sequence_req = 32'd1;
                    if (it.kind == KIND_NOTE && pick >= 50) it.sequence_req = '0;
                end else if (pick < 68) begin
                    it.kind = pick[0] ? KIND_NOTE : KIND_SNAP;
                end else if (pick < 82) begin
                    it.kind = KIND_TICK;
                end else if (pick < 88) begin
                    it.kind = KIND_ACK;
                    if (pick < 85) it.sequence_req = ledger.active_seq;
                end else if (pick < 94) begin
                    it.kind = KIND_CANCEL;
                end else begin
                    it.kind = 3'($urandom_range(5, 7));
                end
            end
        endcase
        return it;
    endfunction

    // Offer one event and hold it until the transfer completes.
    task automatic push_item(t_item it);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= it.kind;
        i_s_axis_tdata  <= {5'd0, it.link_connected, it.radio_ok, it.radio_playing,
                            it.keep_radio, it.snapshot_control, it.chunked_format,
                            it.note_valid, it.message_length, it.sequence_req};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        ledger.log_event(it);
    endtask

    task automatic run_random(int count);
        for (int n = 0; n < count; n++) begin
            push_item(make_item());
            if (idle_on && hold_left == 0 && !hold_request && $urandom_range(0, 7) == 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    endtask

    // Stop offering and wait for every owed response.
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (ledger.owed.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        ledger.set_reg(idx, value);
    endtask

    task automatic load_settings(logic [9:0] retry, logic [9:0] chunk,
                                 logic [15:0] send_limit, logic [15:0] restore_limit);
        write_reg(CFG_RETRY_INTERVAL, 16'(retry));
        write_reg(CFG_CHUNK_INTERVAL, 16'(chunk));
        write_reg(CFG_SEND_TIMEOUT, send_limit);
        write_reg(CFG_RESTORE_TIMEOUT, restore_limit);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_directed();
        t_item it;
        push_item(blank(KIND_TICK));
        push_item(blank(KIND_CANCEL));
        it = blank(KIND_ACK);
        it.sequence_req = '1;
        push_item(it);
        // note refusals: failed text checks, empty, oversize, playback active
        it = blank(KIND_NOTE);
        it.message_length = 11'd5;
        it.radio_ok       = 1'b1;
        push_item(it);
        it.note_valid     = 1'b1;
        it.message_length = '0;
        push_item(it);
        it.message_length = 11'd1025;
        push_item(it);
        it.message_length = '1;
        push_item(it);
        it.message_length = 11'd1;
        it.radio_playing  = 1'b1;
        push_item(it);
        // snapshot refusals: zero sequence, unknown control types
        it = blank(KIND_SNAP);
        it.radio_ok = 1'b1;
        push_item(it);
        it.sequence_req     = 32'd7;
        it.snapshot_control = 2'd2;
        push_item(it);
        it.snapshot_control = 2'd3;
        push_item(it);
        // radio failure with the link up, then busy while restoring
        it = blank(KIND_NOTE);
        it.note_valid     = 1'b1;
        it.message_length = 11'd200;
        it.link_connected = 1'b1;
        push_item(it);
        it.radio_ok = 1'b1;
        push_item(it);
        push_item(blank(KIND_TICK));
        it = blank(KIND_TICK);
        it.link_connected = 1'b1;
        push_item(it);
        // radio failure with the link down goes straight to idle
        it = blank(KIND_SNAP);
        it.sequence_req = '1;
        push_item(it);
        it.radio_ok         = 1'b1;
        it.snapshot_control = SNAP_COMMIT;
        it.keep_radio       = 1'b1;
        it.link_connected   = 1'b1;
        push_item(it);
        push_item(blank(KIND_ACK));
        push_item(blank(KIND_TICK));
        it = blank(KIND_ACK);
        it.sequence_req = '1;
        push_item(it);
        push_item(blank(KIND_TICK));
        // from radio ready: zero random value, longest text, link down
        it = blank(KIND_NOTE);
        it.note_valid     = 1'b1;
        it.message_length = 11'd1024;
        it.chunked_format = 1'b1;
        it.radio_ok       = 1'b1;
        push_item(it);
        it = blank(KIND_ACK);
        it.sequence_req = 32'd1;
        push_item(it);
        push_item(blank(KIND_TICK));
        push_item(blank(KIND_CANCEL));
        it = blank(KIND_TICK);
        it.link_connected = 1'b1;
        push_item(it);
        push_item(blank(KIND_UNUSED));
    endtask

    // Longest chunked note: resend on the chunk interval, rotating the chunk,
    // until the send timeout expires, then recover the link.
    task automatic soak_send_timeout();
        t_item it;
        push_item(blank(KIND_CANCEL));
        it = blank(KIND_TICK);
        it.link_connected = 1'b1;
        push_item(it);
        it = blank(KIND_NOTE);
        it.sequence_req   = 32'h5A5A_0001;
        it.message_length = 11'd1024;
        it.note_valid     = 1'b1;
        it.chunked_format = 1'b1;
        it.radio_ok       = 1'b1;
        it.link_connected = 1'b1;
        push_item(it);
        while (ledger.mode == MODE_CODE_SENDING) push_item(blank(KIND_TICK));
        push_item(blank(KIND_TICK));
        it = blank(KIND_TICK);
        it.link_connected = 1'b1;
        push_item(it);
    endtask

    initial begin
        ledger = new();
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= '0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= '0;
        i_cfg_data      <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_on = 1'b1;
        run_directed();
        drain();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: load_settings(10'd1, 10'd1, 16'd1, 16'd1);
                1: load_settings(10'd1023, 10'd250, 16'd520, 16'd65535);
                default: load_settings(10'($urandom_range(1, 12)), 10'($urandom_range(1, 6)),
                                       16'($urandom_range(8, 80)),
                                       16'($urandom_range(2, 12)));
            endcase
            // phase 4 runs calm, the last phase runs without any idling
            idle_on = (p != 4) && (p != PHASES - 1);
            if (p == 1) begin
                idle_on = 1'b0;
                soak_send_timeout();
                idle_on = 1'b1;
            end
            // stall responses for a long stretch while events keep coming
            if (p == 5) hold_request = 1'b1;
            run_random(PHASE_EVENTS);
            drain();
        end

        if (ledger.owed.size() != 0)
            ledger.flag_mismatch($sformatf("%0d responses never arrived", ledger.owed.size()));
        if (ledger.mismatches == 0) begin
            $display("ack_retransmit_controller test passed");
        end else begin
            $display("ack_retransmit_controller test failed");
        end
        $finish;
    end

endmodule
